// ===== sv/piddr_pkg.sv =====
// Shared constants, types and interface structs for the PID/IIR duty regulator.
// No dependencies; imported by piddr_mac, piddr_div, pid_iir_duty_regulator and tb_top.
package piddr_pkg;

  // Output and fixed-point format
  localparam int DUTY_BITS  = 12;
  localparam int FRAC_BITS  = 16;
  localparam int DUTY_MAX   = (1 << DUTY_BITS) - 1;

  // Field and state widths
  localparam int MV_W       = 12;
  localparam int FB_W       = 21;
  localparam int ERR_W      = 22;
  localparam int DRV_W      = 25;
  localparam int COEF_W     = 32;
  localparam int COEF_FRAC  = 28;
  localparam int RUN_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Serial datapath
  localparam int ACC_W      = 64;
  localparam int MUL_W      = DRV_W;   // multiplier bits, one per cycle
  localparam int Q_W        = FB_W;    // quotient bits, one per cycle
  localparam int DSR_W      = 32;

  // Stream widths, whole bytes
  localparam int S_TDATA_W  = ((MV_W + 7) / 8) * 8;
  localparam int M_TDATA_W  = ((DUTY_BITS + FB_W + 7) / 8) * 8;

  // Cubic correction: 1787 x^3 - 6413000 x^2 + 42716e6 x - 1436e9, scaled by 1e13.
  // Scaling to Q.F is x 2^F / 10^13 = x 2^(F-13) / 5^13.
  localparam int POLY_SH  = (FRAC_BITS >= 13) ? FRAC_BITS - 13 : 0;
  localparam int POLY_DSH = (FRAC_BITS >= 13) ? 0 : 13 - FRAC_BITS;
  localparam logic [DSR_W-1:0] POLY_DIV  = DSR_W'(64'd1220703125 << POLY_DSH);
  localparam logic [ACC_W-1:0] POLY_HALF = ACC_W'(POLY_DIV / 2);
  localparam logic signed [ACC_W-1:0] POLY_C3 = 64'sd1787;
  localparam logic signed [ACC_W-1:0] POLY_C2 = -64'sd6413000;
  localparam logic signed [ACC_W-1:0] POLY_C1 = 64'sd42716000000;
  localparam logic signed [ACC_W-1:0] POLY_C0 = -64'sd1436000000000;

  // Duty scaling: floor(y * DUTY_MAX / (12 * 2^F))
  localparam logic [DSR_W-1:0] DUTY_DIV = DSR_W'(64'd12 << FRAC_BITS);

  // Register reset values
  localparam logic signed [FB_W-1:0]   SETPOINT_RST = 21'sd393216;
  localparam logic signed [COEF_W-1:0] B0_RST       = 32'sd184411524;
  localparam logic signed [COEF_W-1:0] B1_RST       = -32'sd350318351;
  localparam logic signed [COEF_W-1:0] B2_RST       = 32'sd166212384;
  localparam logic signed [COEF_W-1:0] A1_RST       = -32'sd507708985;
  localparam logic signed [COEF_W-1:0] A2_RST       = 32'sd239273529;
  localparam logic [RUN_W-1:0]         RUN_RST      = 16'd2000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT = 3'd0,
    REG_B0       = 3'd1,
    REG_B1       = 3'd2,
    REG_B2       = 3'd3,
    REG_A1       = 3'd4,
    REG_A2       = 3'd5,
    REG_RUN_LEN  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic                    start;
    logic                    load_acc;  // preset accumulator with addend
    logic signed [ACC_W-1:0] addend;
    logic signed [ACC_W-1:0] mcand;
    logic signed [MUL_W-1:0] mplier;
  } mac_cmd_t;

  typedef struct packed {
    logic                    busy;
    logic signed [ACC_W-1:0] acc;
  } mac_sts_t;

  typedef struct packed {
    logic             start;
    logic [ACC_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_cmd_t;

  typedef struct packed {
    logic           busy;
    logic           ovf;   // quotient does not fit in Q_W bits
    logic [Q_W-1:0] quo;
  } div_sts_t;

endpackage

// ===== sv/piddr_mac.sv =====
// Bit-serial signed shift-add multiply-accumulate, one multiplier bit per cycle.
// Depends on piddr_pkg.
module piddr_mac import piddr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mac_cmd_t cmd_i,
  output mac_sts_t sts_o
);

  localparam int CNT_W = $clog2(MUL_W);

  logic                    busy_q, busy_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [ACC_W-1:0] mcand_q, mcand_d;
  logic [MUL_W-1:0]        mpl_q, mpl_d;
  logic                    last;
  logic [ACC_W-1:0]        term;

  always_comb begin
    last    = (cnt_q == CNT_W'(MUL_W - 1));
    // sign bit of the multiplier has negative weight: add ~mcand + 1
    term    = mcand_q ^ {ACC_W{last}};
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    mcand_d = mcand_q;
    mpl_d   = mpl_q;
    if (cmd_i.start) begin
      busy_d  = 1'b1;
      cnt_d   = '0;
      acc_d   = cmd_i.load_acc ? cmd_i.addend : acc_q;
      mcand_d = cmd_i.mcand;
      mpl_d   = cmd_i.mplier;
    end else if (busy_q) begin
      if (mpl_q[0]) begin
        acc_d = acc_q + term + ACC_W'(last);
      end
      mcand_d = mcand_q <<< 1;
      mpl_d   = mpl_q >> 1;
      cnt_d   = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    mcand_q <= mcand_d;
    mpl_q   <= mpl_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.acc  = acc_q;

`ifndef NO_ASSERTIONS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |-> !busy_q)
    else $error("multiply started while a pass is running");
`endif

endmodule

// ===== sv/piddr_div.sv =====
// Restoring divider, one quotient bit per cycle, with an overflow flag.
// Depends on piddr_pkg.
module piddr_div import piddr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_cmd_t cmd_i,
  output div_sts_t sts_o
);

  localparam int CNT_W = $clog2(Q_W);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [ACC_W-1:0] rem_q, rem_d;
  logic [ACC_W-1:0] dsr_q, dsr_d;
  logic [Q_W-1:0]   quo_q, quo_d;
  logic             ovf_q, ovf_d;
  logic             ge;

  always_comb begin
    ge     = (rem_q >= dsr_q);
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    ovf_d  = ovf_q;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = cmd_i.dividend;
      dsr_d  = ACC_W'(cmd_i.divisor) << (Q_W - 1);
      quo_d  = '0;
      ovf_d  = (cmd_i.dividend >= (ACC_W'(cmd_i.divisor) << Q_W));
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - dsr_q;
      end
      quo_d = {quo_q[Q_W-2:0], ge};
      dsr_d = dsr_q >> 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(Q_W - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.ovf  = ovf_q;
  assign sts_o.quo  = quo_q;

`ifndef NO_ASSERTIONS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |-> !busy_q)
    else $error("division started while one is running");
`endif

endmodule

// ===== sv/pid_iir_duty_regulator.sv =====
// Duty regulator top level: stream ports, register file, sequencer, result register.
// Depends on piddr_pkg, piddr_mac and piddr_div.
//
// One feedback sample (millivolts) in, one result out: PWM duty, the corrected
// feedback voltage (signed Q4.16) and a done flag. The sample is scaled to volts,
// corrected by a fixed cubic, subtracted from the setpoint, and filtered by a
// second-order direct-form-I IIR (PID with filtered derivative) with Q3.28
// coefficients; the drive is scaled by DUTY_MAX/12 and clamped. All arithmetic
// runs on one shift-add multiplier (one multiplier bit per cycle) and one
// restoring divider (one quotient bit per cycle). A regulated sample runs three
// Horner passes and five filter terms on the multiplier and two divider runs,
// with sequencing states between them. When the drive is not positive the duty
// division is skipped. Once run_length samples have been regulated, each
// request is answered with duty 0, feedback 0 and done set: it goes straight
// to S_OUT and from there to the output register, and the filter state stays
// frozen. One sample is in flight at a time; the next request is taken as soon
// as the result has moved to the output register, even while that register
// still waits for m_axis_tready_i. Configuration is to be written only while
// idle by the user; the block itself does not enforce it. There is no
// read-back and unknown indexes are ignored.
module pid_iir_duty_regulator import piddr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // feedback request
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata_i,   // [11:0] feedback_mv
  // result
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [M_TDATA_W-1:0]  m_axis_tdata_o,   // [11:0] duty, [32:12] corrected_feedback
  output logic                  m_axis_tuser_o,   // [0] done_res
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_POLY   = 9'b000000010,  // Horner passes of the cubic
    S_PDIV   = 9'b000000100,  // scale cubic to Q.F
    S_ERR    = 9'b000001000,
    S_FILT   = 9'b000010000,  // five filter terms
    S_ROUND  = 9'b000100000,
    S_DSTART = 9'b001000000,  // history update, start duty scaling
    S_DDIV   = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_e;

  typedef enum logic [2:0] {
    T_ERR = 3'd0,
    T_E0  = 3'd1,
    T_E1  = 3'd2,
    T_Y0  = 3'd3,
    T_Y1  = 3'd4
  } term_e;

  localparam logic [1:0] POLY_LAST = 2'd2;
  localparam logic [FB_W-1:0] FB_POS = {1'b0, {(FB_W-1){1'b1}}};
  localparam logic [FB_W-1:0] FB_NEG = {1'b1, {(FB_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] RND_HALF  = ACC_W'(1) <<< (COEF_FRAC - 1);
  localparam logic signed [ACC_W-1:0] DRV_MAX_S = (ACC_W'(1) <<< (DRV_W - 1)) - 1;
  localparam logic signed [ACC_W-1:0] DRV_MIN_S = -(ACC_W'(1) <<< (DRV_W - 1));
  localparam logic [DRV_W-1:0] DRV_POS = {1'b0, {(DRV_W-1){1'b1}}};
  localparam logic [DRV_W-1:0] DRV_NEG = {1'b1, {(DRV_W-1){1'b0}}};

  // configuration
  logic signed [FB_W-1:0]   setpoint_q;
  logic signed [COEF_W-1:0] b0_q, b1_q, b2_q, a1_q, a2_q;
  logic [RUN_W-1:0]         run_len_q;

  // sequencer
  state_e     state_q, state_d;
  logic [1:0] step_q, step_d;
  term_e      term_q, term_d, term_nx;

  // per-sample working values
  logic [MV_W-1:0]         x_q, x_d;
  logic                    neg_q, neg_d;
  logic signed [FB_W-1:0]  fb_q, fb_d;
  logic signed [ERR_W-1:0] err_q, err_d;
  logic signed [DRV_W-1:0] y_q, y_d;
  logic [DUTY_BITS-1:0]    res_duty_q, res_duty_d;
  logic                    res_done_q, res_done_d;

  // filter state
  logic signed [ERR_W-1:0] e0_q, e1_q;
  logic signed [DRV_W-1:0] y0_q, y1_q;
  logic [RUN_W-1:0]        cnt_q;

  // result register
  logic                 out_valid_q, out_valid_d;
  logic [DUTY_BITS-1:0] out_duty_q;
  logic [FB_W-1:0]      out_fb_q;
  logic                 out_done_q;
  logic                 out_load;

  // serial units
  mac_cmd_t mac_cmd;
  mac_sts_t mac_sts;
  div_cmd_t div_cmd;
  div_sts_t div_sts;

  // datapath helpers
  logic                    run_over;
  logic [MUL_W-1:0]        x_ext;
  logic signed [ACC_W-1:0] num_sh;
  logic [ACC_W-1:0]        poly_dvd;
  logic signed [FB_W-1:0]  fb_sat;
  logic signed [ERR_W-1:0] err_calc;
  logic signed [ACC_W-1:0] rnd_sum, rnd_val;
  logic signed [DRV_W-1:0] y_sat;
  logic                    y_pos;
  logic [ACC_W-1:0]        duty_dvd;
  logic [DUTY_BITS-1:0]    duty_sat;
  logic signed [ACC_W-1:0] coef_nx;
  logic signed [MUL_W-1:0] hist_nx;

  piddr_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mac_cmd),
    .sts_o  (mac_sts)
  );

  piddr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (div_cmd),
    .sts_o  (div_sts)
  );

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q <= SETPOINT_RST;
      b0_q       <= B0_RST;
      b1_q       <= B1_RST;
      b2_q       <= B2_RST;
      a1_q       <= A1_RST;
      a2_q       <= A2_RST;
      run_len_q  <= RUN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_SETPOINT: setpoint_q <= cfg_data_i[FB_W-1:0];
        REG_B0:       b0_q       <= cfg_data_i[COEF_W-1:0];
        REG_B1:       b1_q       <= cfg_data_i[COEF_W-1:0];
        REG_B2:       b2_q       <= cfg_data_i[COEF_W-1:0];
        REG_A1:       a1_q       <= cfg_data_i[COEF_W-1:0];
        REG_A2:       a2_q       <= cfg_data_i[COEF_W-1:0];
        REG_RUN_LEN:  run_len_q  <= cfg_data_i[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  // datapath terms
  always_comb begin
    run_over = (cnt_q >= run_len_q);
    x_ext    = MUL_W'(x_q);

    // |num| << sh + d/2, sign folded into one add or subtract
    num_sh   = mac_sts.acc <<< POLY_SH;
    poly_dvd = mac_sts.acc[ACC_W-1] ? (POLY_HALF - num_sh) : (num_sh + POLY_HALF);

    // quotient is a magnitude; restore sign and saturate to Q4.16
    if (neg_q) begin
      fb_sat = (div_sts.ovf || (div_sts.quo > FB_NEG)) ? FB_NEG : -div_sts.quo;
    end else begin
      fb_sat = (div_sts.ovf || (div_sts.quo > FB_POS)) ? FB_POS : div_sts.quo;
    end

    err_calc = ERR_W'(setpoint_q) - ERR_W'(fb_q);

    // Q(F+28) -> Q.F, halves up, then saturate to the drive range
    rnd_sum = mac_sts.acc + RND_HALF;
    rnd_val = rnd_sum >>> COEF_FRAC;
    if (rnd_val > DRV_MAX_S) begin
      y_sat = DRV_POS;
    end else if (rnd_val < DRV_MIN_S) begin
      y_sat = DRV_NEG;
    end else begin
      y_sat = rnd_val[DRV_W-1:0];
    end

    y_pos    = !y_q[DRV_W-1] && (y_q != '0);
    duty_dvd = (ACC_W'(y_q) << DUTY_BITS) - ACC_W'(y_q);
    duty_sat = (div_sts.ovf || (div_sts.quo > Q_W'(DUTY_MAX))) ?
               DUTY_BITS'(DUTY_MAX) : div_sts.quo[DUTY_BITS-1:0];

    // operands of the next filter term; a-terms are subtracted
    term_nx = term_e'(term_q + 3'd1);
    case (term_nx)
      T_E0: begin
        coef_nx = ACC_W'(b1_q);
        hist_nx = MUL_W'(e0_q);
      end
      T_E1: begin
        coef_nx = ACC_W'(b2_q);
        hist_nx = MUL_W'(e1_q);
      end
      T_Y0: begin
        coef_nx = -ACC_W'(a1_q);
        hist_nx = y0_q;
      end
      T_Y1: begin
        coef_nx = -ACC_W'(a2_q);
        hist_nx = y1_q;
      end
      default: begin
        coef_nx = ACC_W'(b0_q);
        hist_nx = MUL_W'(err_q);
      end
    endcase
  end

  // sequencer
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign out_load        = (state_q == S_OUT) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    term_d     = term_q;
    x_d        = x_q;
    neg_d      = neg_q;
    fb_d       = fb_q;
    err_d      = err_q;
    y_d        = y_q;
    res_duty_d = res_duty_q;
    res_done_d = res_done_q;
    mac_cmd    = '0;
    div_cmd    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          x_d = s_axis_tdata_i[MV_W-1:0];
          if (run_over) begin
            res_duty_d = '0;
            fb_d       = '0;
            res_done_d = 1'b1;
            state_d    = S_OUT;
          end else begin
            res_done_d       = 1'b0;
            step_d           = '0;
            mac_cmd.start    = 1'b1;
            mac_cmd.load_acc = 1'b1;
            mac_cmd.addend   = POLY_C2;
            mac_cmd.mcand    = POLY_C3;
            mac_cmd.mplier   = MUL_W'(s_axis_tdata_i[MV_W-1:0]);
            state_d          = S_POLY;
          end
        end
      end
      S_POLY: begin
        if (!mac_sts.busy) begin
          if (step_q == POLY_LAST) begin
            neg_d            = mac_sts.acc[ACC_W-1];
            div_cmd.start    = 1'b1;
            div_cmd.dividend = poly_dvd;
            div_cmd.divisor  = POLY_DIV;
            state_d          = S_PDIV;
          end else begin
            step_d           = step_q + 2'd1;
            mac_cmd.start    = 1'b1;
            mac_cmd.load_acc = 1'b1;
            mac_cmd.addend   = (step_q == '0) ? POLY_C1 : POLY_C0;
            mac_cmd.mcand    = mac_sts.acc;
            mac_cmd.mplier   = x_ext;
          end
        end
      end
      S_PDIV: begin
        if (!div_sts.busy) begin
          fb_d    = fb_sat;
          state_d = S_ERR;
        end
      end
      S_ERR: begin
        err_d            = err_calc;
        term_d           = T_ERR;
        mac_cmd.start    = 1'b1;
        mac_cmd.load_acc = 1'b1;
        mac_cmd.addend   = '0;
        mac_cmd.mcand    = ACC_W'(b0_q);
        mac_cmd.mplier   = MUL_W'(err_calc);
        state_d          = S_FILT;
      end
      S_FILT: begin
        if (!mac_sts.busy) begin
          if (term_q == T_Y1) begin
            state_d = S_ROUND;
          end else begin
            term_d         = term_nx;
            mac_cmd.start  = 1'b1;
            mac_cmd.mcand  = coef_nx;
            mac_cmd.mplier = hist_nx;
          end
        end
      end
      S_ROUND: begin
        y_d     = y_sat;
        state_d = S_DSTART;
      end
      S_DSTART: begin
        if (y_pos) begin
          div_cmd.start    = 1'b1;
          div_cmd.dividend = duty_dvd;
          div_cmd.divisor  = DUTY_DIV;
          state_d          = S_DDIV;
        end else begin
          res_duty_d = '0;
          state_d    = S_OUT;
        end
      end
      S_DDIV: begin
        if (!div_sts.busy) begin
          res_duty_d = duty_sat;
          state_d    = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      term_q      <= T_ERR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      term_q      <= term_d;
      out_valid_q <= out_valid_d;
    end
  end

  // filter history and sample count advance once per regulated sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e0_q  <= '0;
      e1_q  <= '0;
      y0_q  <= '0;
      y1_q  <= '0;
      cnt_q <= '0;
    end else if (state_q == S_DSTART) begin
      e1_q  <= e0_q;
      e0_q  <= err_q;
      y1_q  <= y0_q;
      y0_q  <= y_q;
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    neg_q      <= neg_d;
    fb_q       <= fb_d;
    err_q      <= err_d;
    y_q        <= y_d;
    res_duty_q <= res_duty_d;
    res_done_q <= res_done_d;
    if (out_load) begin
      out_duty_q <= res_duty_q;
      out_fb_q   <= fb_q;
      out_done_q <= res_done_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(M_TDATA_W - DUTY_BITS - FB_W){1'b0}}, out_fb_q, out_duty_q};
  assign m_axis_tuser_o  = out_done_q;

`ifndef NO_ASSERTIONS
  a_run_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && run_over |=> (state_q == S_OUT) && res_done_q)
    else $error("finished run did not answer directly");

  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mac_sts.busy && div_sts.busy))
    else $error("multiplier and divider busy together");

  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> (out_duty_q == '0) && (out_fb_q == '0))
    else $error("done result carries nonzero payload");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_DSTART |=> cnt_q == $past(cnt_q))
    else $error("sample count moved outside history update");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for pid_iir_duty_regulator: feedback requests in, duty results out.
// Depends on piddr_pkg and the regulator RTL; it holds its own bit-exact regulator predictor.
module tb_top;
  import piddr_pkg::*;

  // Register index with no register behind it; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  // Volts scaling: the cubic is worked at 1e13, so Q.F = x * 2^(F-13) / 5^13.
  localparam int              VOLT_SH    = FRAC_BITS - 13;
  localparam longint unsigned FIVE_POW13 = 64'd1220703125;

  localparam int PHASES    = 10;
  localparam int PHASE_LEN = 168;

  typedef struct packed {
    logic [DUTY_BITS-1:0]   duty;
    logic signed [FB_W-1:0] fb;
    logic                   done;
  } duty_result_t;

  // clock, reset, DUT pins
  logic                  clk_i    = 1'b0;
  logic                  rst_ni   = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic [S_TDATA_W-1:0]  s_tdata  = '0;
  logic                  s_tready;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  m_tuser;
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // register mirror, reset values
  logic signed [FB_W-1:0]   sp_q      = SETPOINT_RST;
  logic signed [COEF_W-1:0] b0_q      = B0_RST;
  logic signed [COEF_W-1:0] b1_q      = B1_RST;
  logic signed [COEF_W-1:0] b2_q      = B2_RST;
  logic signed [COEF_W-1:0] a1_q      = A1_RST;
  logic signed [COEF_W-1:0] a2_q      = A2_RST;
  logic [RUN_W-1:0]         run_len_q = RUN_RST;

  // filter state mirror, [0] newest
  logic signed [ERR_W-1:0] err_hist [2];
  logic signed [DRV_W-1:0] drv_hist [2];
  logic [RUN_W-1:0]        regulated_cnt = '0;

  logic [MV_W-1:0] pending_mv [$];        // feedback samples not yet requested
  duty_result_t    expected_duty [$];     // predicted results, oldest first
  duty_result_t    got_res, want_res;

  logic        req_fire = 1'b0;           // request handshake seen at last rising edge
  logic        res_fire = 1'b0;           // result handshake seen at last rising edge
  logic        no_idle  = 1'b0;           // phase without any gaps on either side
  int unsigned src_gap  = 0;
  int unsigned sink_gap = 0;
  int          mismatches = 0;

  initial begin
    err_hist[0] = '0; err_hist[1] = '0;
    drv_hist[0] = '0; drv_hist[1] = '0;
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  pid_iir_duty_regulator u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic longint clip(longint v, int w);
    longint hi, lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Cubic correction of mv/1000, rounded once half away from zero, then
  // saturated to the Q4.16 feedback range (full scale saturates).
  function automatic longint cubic_volts(logic [MV_W-1:0] mv);
    longint          x, num;
    longint unsigned mag, q;
    x   = longint'(mv);
    num = 64'sd1787 * x * x * x - 64'sd6413000 * x * x
        + 64'sd42716000000 * x - 64'sd1436000000000;
    mag = (num < 0) ? unsigned'(-num) : unsigned'(num);
    q   = ((mag << VOLT_SH) + FIVE_POW13 / 2) / FIVE_POW13;
    return clip((num < 0) ? -longint'(q) : longint'(q), FB_W);
  endfunction

  // One regulator step; advances the filter state unless the run is over.
  function automatic duty_result_t regulate(logic [MV_W-1:0] mv);
    duty_result_t    r;
    longint          fb, err, acc, y;
    longint unsigned d;
    r = '0;
    if (regulated_cnt >= run_len_q) begin
      // run finished: duty 0, feedback 0, done; state frozen
      r.done = 1'b1;
      return r;
    end
    fb  = cubic_volts(mv);
    err = longint'(sp_q) - fb;
    acc = longint'(b0_q) * err
        + longint'(b1_q) * longint'(err_hist[0])
        + longint'(b2_q) * longint'(err_hist[1])
        - longint'(a1_q) * longint'(drv_hist[0])
        - longint'(a2_q) * longint'(drv_hist[1]);
    // Q(F+28) -> Q.F, halves up, then saturate the drive
    y = clip((acc + (64'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC, DRV_W);
    d = 0;
    if (y > 0) begin
      d = (unsigned'(y) * DUTY_MAX) / (64'd12 << FRAC_BITS);
      if (d > DUTY_MAX) d = DUTY_MAX;
    end
    err_hist[1]   = err_hist[0];
    err_hist[0]   = err[ERR_W-1:0];
    drv_hist[1]   = drv_hist[0];
    drv_hist[0]   = y[DRV_W-1:0];
    regulated_cnt = regulated_cnt + 1'b1;
    r.duty = d[DUTY_BITS-1:0];
    r.fb   = fb[FB_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Gaps: mostly none or short, now and then long; none at all in quiet phases
  // ---------------------------------------------------------------------------

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 4);
    if (r < 98) return $urandom_range(5, 30);
    return $urandom_range(100, 300);
  endfunction

  // ---------------------------------------------------------------------------
  // Request side: driver at the falling edge, handshake taken at the rising edge
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (rst_ni && (!s_tvalid || req_fire)) begin
      if (req_fire) src_gap = pick_gap();
      if (src_gap == 0 && pending_mv.size() != 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(pending_mv[0]);
      end else begin
        s_tvalid <= 1'b0;
        if (src_gap != 0) src_gap--;
      end
    end
  end

  always @(posedge clk_i) begin
    req_fire <= rst_ni && s_tvalid && s_tready;
    if (rst_ni && s_tvalid && s_tready) begin
      expected_duty.push_back(regulate(s_tdata[MV_W-1:0]));
      void'(pending_mv.pop_front());
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: backpressure at the falling edge, checks at the rising edge
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (res_fire || (sink_gap == 0 && $urandom_range(0, 7) == 0)) sink_gap = pick_gap();
      if (sink_gap != 0) begin
        m_tready <= 1'b0;
        sink_gap--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic note_mismatch(string what, longint want, longint got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
  endtask

  always @(posedge clk_i) begin
    res_fire <= rst_ni && m_tvalid && m_tready;
    if (rst_ni && m_tvalid && m_tready) begin
      got_res.duty = m_tdata[DUTY_BITS-1:0];
      got_res.fb   = m_tdata[DUTY_BITS +: FB_W];
      got_res.done = m_tuser;
      if (expected_duty.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual duty %0d fb %0d done %0d",
                 $time, got_res.duty, got_res.fb, got_res.done);
      end else begin
        want_res = expected_duty.pop_front();
        if (got_res.duty != want_res.duty)
          note_mismatch("duty", want_res.duty, got_res.duty);
        if (got_res.fb != want_res.fb)
          note_mismatch("corrected_feedback", want_res.fb, got_res.fb);
        if (got_res.done != want_res.done)
          note_mismatch("done_res", want_res.done, got_res.done);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration and stimulus
  // ---------------------------------------------------------------------------

  // Register write at a falling edge; mirror follows at once (block is idle).
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      REG_SETPOINT: sp_q      = data[FB_W-1:0];
      REG_B0:       b0_q      = data;
      REG_B1:       b1_q      = data;
      REG_B2:       b2_q      = data;
      REG_A1:       a1_q      = data;
      REG_A2:       a2_q      = data;
      REG_RUN_LEN:  run_len_q = data[RUN_W-1:0];
      default: ;
    endcase
  endtask

  // Wait until every request went in and every result came back.
  task automatic drain();
    while (pending_mv.size() != 0 || expected_duty.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_setpoint();
    logic signed [FB_W-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = {1'b0, {(FB_W-1){1'b1}}};
      1:       v = {1'b1, {(FB_W-1){1'b0}}};
      2:       v = FB_W'($urandom());
      default: v = SETPOINT_RST + FB_W'($urandom_range(0, 262144)) - FB_W'(131072);
    endcase
    return CFG_DATA_W'(v);
  endfunction

  // Coefficients: mostly a perturbed tuned value, sometimes random or at a rail.
  function automatic logic [CFG_DATA_W-1:0] pick_coef(logic signed [COEF_W-1:0] nominal);
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom();
      default: return nominal + COEF_W'($urandom_range(0, 2097152)) - COEF_W'(1048576);
    endcase
  endfunction

  // Half the samples sit near the operating point, the rest spread or at corners.
  function automatic logic [MV_W-1:0] pick_mv();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return MV_W'($urandom_range(1450, 1850));
    if (r < 80) return MV_W'($urandom_range(0, 4095));
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return MV_W'($urandom_range(0, 15));
      default: return MV_W'($urandom_range(4080, 4095));
    endcase
  endfunction

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Reset settings: rails of the sample, alternating bits, zeros then a hold
    // at the operating point so the drive swings between clamp and zero.
    @(posedge clk_i);
    pending_mv.push_back(12'd0);    pending_mv.push_back(12'd0);
    pending_mv.push_back(12'd0);    pending_mv.push_back(12'd4095);
    pending_mv.push_back(12'd4095); pending_mv.push_back(12'd1);
    pending_mv.push_back(12'd4094); pending_mv.push_back(12'd2048);
    pending_mv.push_back(12'd2047); pending_mv.push_back(12'haaa);
    pending_mv.push_back(12'h555);  pending_mv.push_back(12'd1650);
    pending_mv.push_back(12'd1650); pending_mv.push_back(12'd1650);
    drain();

    // Every register but B2 (zero) at a rail: drive saturates, duty clamps both ways.
    write_reg(REG_SETPOINT, 32'h000f_ffff);
    write_reg(REG_B0, 32'h7fff_ffff);
    write_reg(REG_B1, 32'h8000_0000);
    write_reg(REG_B2, 32'h0000_0000);
    write_reg(REG_A1, 32'h8000_0000);
    write_reg(REG_A2, 32'h7fff_ffff);
    write_reg(REG_RUN_LEN, 32'h0000_ffff);
    @(posedge clk_i);
    pending_mv.push_back(12'd0);    pending_mv.push_back(12'd4095);
    pending_mv.push_back(12'd1650);
    drain();
    write_reg(REG_SETPOINT, 32'hfff0_0000);
    @(posedge clk_i);
    pending_mv.push_back(12'd4095); pending_mv.push_back(12'd0);
    pending_mv.push_back(12'd2048);
    drain();

    // Zero run length: done at once. The spare index must not land anywhere.
    write_reg(REG_RUN_LEN, 32'h0000_0000);
    write_reg(REG_SPARE, 32'hffff_ffff);
    @(posedge clk_i);
    pending_mv.push_back(12'd1650); pending_mv.push_back(12'd4095);
    pending_mv.push_back(12'd0);
    drain();

    // Random phases with fresh settings each time.
    for (int p = 0; p < PHASES; p++) begin
      no_idle = (p % 4 == 2);
      if (p == 0) begin
        // back to the tuned loop
        write_reg(REG_SETPOINT, CFG_DATA_W'(SETPOINT_RST));
        write_reg(REG_B0, B0_RST);
        write_reg(REG_B1, B1_RST);
        write_reg(REG_B2, B2_RST);
        write_reg(REG_A1, A1_RST);
        write_reg(REG_A2, A2_RST);
      end else begin
        write_reg(REG_SETPOINT, pick_setpoint());
        write_reg(REG_B0, pick_coef(B0_RST));
        write_reg(REG_B1, pick_coef(B1_RST));
        write_reg(REG_B2, pick_coef(B2_RST));
        write_reg(REG_A1, pick_coef(A1_RST));
        write_reg(REG_A2, pick_coef(A2_RST));
      end
      if (p == 4)
        // run ends halfway through the phase
        write_reg(REG_RUN_LEN, CFG_DATA_W'(regulated_cnt + RUN_W'(PHASE_LEN / 2)));
      else if (p == 7)
        // run length lowered below the count already reached
        write_reg(REG_RUN_LEN, CFG_DATA_W'(regulated_cnt - 1'b1 - RUN_W'($urandom_range(0, 5))));
      else
        write_reg(REG_RUN_LEN, 32'h0000_ffff);
      @(posedge clk_i);
      for (int n = 0; n < PHASE_LEN; n++) pending_mv.push_back(pick_mv());
      drain();
    end

    repeat (300) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (every request and result
  // behind a long gap plus the full regulation time).
  initial begin
    #60_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
